// ===== sv/b64d_pkg.sv =====
// Shared types, codes and the character classifier for the base64 decoder.
// Used by the front end, the job queue, the result serializer and the top level.
package b64d_pkg;

	typedef enum logic [2:0] {
		ST_DATA       = 3'd0,
		ST_WHITESPACE = 3'd1,
		ST_BAD_LENGTH = 3'd2,
		ST_INVALID    = 3'd3,
		ST_BAD_PAD    = 3'd4
	} b64d_status_t;

	typedef enum logic [1:0] {
		GE_NONE    = 2'd0,
		GE_INVALID = 2'd1,
		GE_BAD_PAD = 2'd2
	} b64d_group_err_t;

	typedef enum logic [1:0] {
		CK_SEXTET = 2'd0,
		CK_PAD    = 2'd1,
		CK_BAD    = 2'd2
	} b64d_kind_t;

	typedef struct packed {
		b64d_kind_t  kind;
		logic [5:0]  value;
	} b64d_cls_t;

	// One queue entry: up to three results that one character causes.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      count;
		b64d_status_t    status;
		logic            msg_end;
	} b64d_job_t;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_PAD   = 8'h3D;
	localparam logic [5:0] SEXTET_LOWER = 6'd26;
	localparam logic [5:0] SEXTET_DIGIT = 6'd52;
	localparam logic [5:0] SEXTET_PLUS  = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;

	function automatic b64d_cls_t b64d_classify(input logic [7:0] c);
		b64d_cls_t r;
		logic [7:0] d;
		r.kind  = CK_BAD;
		r.value = 6'd0;
		d = 8'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'h41;
			r.kind  = CK_SEXTET;
			r.value = d[5:0];
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'h61;
			r.kind  = CK_SEXTET;
			r.value = d[5:0] + SEXTET_LOWER;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
			r.kind  = CK_SEXTET;
			r.value = d[5:0] + SEXTET_DIGIT;
		end else if (c == CHAR_PLUS) begin
			r.kind  = CK_SEXTET;
			r.value = SEXTET_PLUS;
		end else if (c == CHAR_SLASH) begin
			r.kind  = CK_SEXTET;
			r.value = SEXTET_SLASH;
		end else if (c == CHAR_PAD) begin
			r.kind = CK_PAD;
		end
		return r;
	endfunction

	function automatic logic b64d_blank_char(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

endpackage

// ===== sv/b64d_front.sv =====
// Front end: accepts characters, tracks the open group and message status, and
// queues a job for a clean closing group or a message end. Depends on b64d_pkg.
module b64d_front import b64d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  logic [7:0] char_code,
	input  logic      last_char,
	output logic      push,
	output b64d_job_t job
);

	logic [2:0][5:0]  held_q;
	logic [2:0]       pads_q;
	logic [1:0]       pos_q;
	logic             inv_q;
	logic             ws_q;
	b64d_group_err_t  fge_q;

	logic [2:0][5:0]  held_d;
	logic [2:0]       pads_d;
	logic [1:0]       pos_d;
	logic             inv_d;
	logic             ws_d;
	b64d_group_err_t  fge_d;

	b64d_cls_t        cls;
	b64d_group_err_t  err;
	b64d_status_t     st;
	logic [1:0]       n;
	logic             p2;
	logic             p3;
	logic [5:0]       s3;
	logic [23:0]      triple;

	always_comb begin
		cls    = b64d_classify(char_code);
		held_d = held_q;
		pads_d = pads_q;
		pos_d  = pos_q;
		inv_d  = inv_q;
		ws_d   = ws_q | b64d_blank_char(char_code);
		fge_d  = fge_q;
		err    = GE_NONE;
		n      = 2'd0;
		p2     = pads_q[2];
		p3     = (cls.kind == CK_PAD);
		s3     = (cls.kind == CK_SEXTET) ? cls.value : 6'd0;
		triple = {held_q[0], held_q[1], held_q[2], s3};
		st     = ST_DATA;
		if (pos_q != 2'd3) begin
			held_d[pos_q] = (cls.kind == CK_SEXTET) ? cls.value : 6'd0;
			if (cls.kind == CK_BAD) begin
				inv_d = 1'b1;
			end
			if (cls.kind == CK_PAD) begin
				pads_d[pos_q] = 1'b1;
			end
			pos_d = pos_q + 2'd1;
		end else begin
			if (inv_q || cls.kind == CK_BAD) begin
				err = GE_INVALID;
			end else if (pads_q[1:0] != 2'b00 || (p2 && !p3)) begin
				err = GE_BAD_PAD;
			end
			if (err != GE_NONE && fge_q == GE_NONE) begin
				fge_d = err;
			end
			if (err == GE_NONE && !ws_d && fge_q == GE_NONE) begin
				n = p2 ? 2'd1 : (p3 ? 2'd2 : 2'd3);
			end
			held_d = '0;
			pads_d = '0;
			inv_d  = 1'b0;
			pos_d  = 2'd0;
		end
		if (ws_d) begin
			st = ST_WHITESPACE;
		end else if (pos_d != 2'd0) begin
			st = ST_BAD_LENGTH;
		end else begin
			unique case (fge_d)
				GE_INVALID: st = ST_INVALID;
				GE_BAD_PAD: st = ST_BAD_PAD;
				default:    st = ST_DATA;
			endcase
		end
		job.bytes[0] = triple[23:16];
		job.bytes[1] = triple[15:8];
		job.bytes[2] = triple[7:0];
		job.count    = n;
		job.status   = ST_DATA;
		job.msg_end  = last_char;
		push         = accept && (last_char || n != 2'd0);
		if (last_char && (st != ST_DATA || n == 2'd0)) begin
			job.bytes  = '0;
			job.count  = 2'd1;
			job.status = (st == ST_DATA) ? ST_BAD_LENGTH : st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			pads_q <= '0;
			pos_q  <= 2'd0;
			inv_q  <= 1'b0;
			ws_q   <= 1'b0;
			fge_q  <= GE_NONE;
		end else if (accept) begin
			if (last_char) begin
				held_q <= '0;
				pads_q <= '0;
				pos_q  <= 2'd0;
				inv_q  <= 1'b0;
				ws_q   <= 1'b0;
				fge_q  <= GE_NONE;
			end else begin
				held_q <= held_d;
				pads_q <= pads_d;
				pos_q  <= pos_d;
				inv_q  <= inv_d;
				ws_q   <= ws_d;
				fge_q  <= fge_d;
			end
		end
	end

endmodule

// ===== sv/b64d_queue.sv =====
// Short job queue between the front end and the result serializer.
// Depends on b64d_pkg for the job type.
module b64d_queue import b64d_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  b64d_job_t wr_job,
	input  logic      pop,
	output b64d_job_t head,
	output logic      full,
	output logic      empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	b64d_job_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/b64d_back.sv =====
// Result serializer: walks the head job one result per cycle, while the output
// is not stalled, into the output register. Depends on b64d_pkg for the job and status types.
module b64d_back import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  b64d_job_t  head,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic [2:0] status,
	output logic       run_end,
	output logic       message_end
);

	logic [1:0]  idx_q;
	logic        valid_q;
	logic [7:0]  byte_q;
	logic [2:0]  status_q;
	logic        run_end_q;
	logic        msg_end_q;
	logic        load;
	logic        is_last;
	logic [7:0]  sel_byte;

	assign load    = !empty && (!valid_q || !out_stall);
	assign is_last = ((idx_q + 2'd1) == head.count);
	assign pop     = load && is_last;

	always_comb begin
		unique case (idx_q)
			2'd0:    sel_byte = head.bytes[0];
			2'd1:    sel_byte = head.bytes[1];
			default: sel_byte = head.bytes[2];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q    <= sel_byte;
			status_q  <= head.status;
			run_end_q <= is_last;
			msg_end_q <= is_last && head.msg_end;
		end
	end

	assign out_valid   = valid_q;
	assign data_byte   = byte_q;
	assign status      = status_q;
	assign run_end     = run_end_q;
	assign message_end = msg_end_q;

endmodule

// ===== sv/base64_strict_decoder_top.sv =====
// Top level of the strict base64 decoder: front end, job queue, serializer.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
// The decoder accepts one character per cycle while its job queue has room.
// Every character is classified and folded into the open group in the cycle
// it is accepted; a character that closes a clean group, or ends the message,
// places one job of one to three results in a QUEUE_DEPTH entry queue. The
// serializer delivers one result per cycle while the consumer does not stall,
// from the queue through an output register, so a full three-byte group
// yields three results and a steady stream of valid text runs at one
// character and 0.75 bytes per cycle. The input stalls only when the queue is
// full, which happens when the consumer stalls. On error the final status
// result follows any bytes already sent, which the consumer discards.
module base64_strict_decoder_top import b64d_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic [2:0] status,
	output logic       run_end,
	output logic       message_end
);

	logic      accept;
	logic      push;
	logic      pop;
	logic      full;
	logic      empty;
	b64d_job_t wr_job;
	b64d_job_t head;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_code (char_code),
		.last_char (last_char),
		.push      (push),
		.job       (wr_job)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	b64d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_byte   (data_byte),
		.status      (status),
		.run_end     (run_end),
		.message_end (message_end)
	);

endmodule
